FILE: design/stdm_pkg.sv
`default_nettype none
package stdm_pkg;

  localparam int WordW  = 16;
  localparam int StampW = 32;
  localparam int SlotW  = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 5;

  localparam logic [CfgIdxW-1:0] CfgSubcom = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSelect = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCount  = 2'd2;

  localparam logic [SlotW-1:0]   IdxMask    = 4'hf;
  localparam logic [4:0]         SelAll     = 5'h1f;
  localparam logic [4:0]         CountReset = 5'd16;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPrep = 4'b0010,
    StEmit = 4'b0100,
    StUpd  = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic start_run;
    logic in_run;
    logic emit_load;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic run_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/stdm_if.sv
`default_nettype none
interface stdm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic [31:0] stamp;
  modport source (output valid, output word, output stamp, input ready);
  modport sink   (input valid, input word, input stamp, output ready);
endinterface

interface stdm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_stamp;
  logic [3:0]  slot;
  logic [15:0] value;
  logic        last;
  modport source (output valid, output out_stamp, output slot, output value, output last,
                  input ready);
  modport sink   (input valid, input out_stamp, input slot, input value, input last,
                  output ready);
endinterface

interface stdm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/stdm_ram.sv
`default_nettype none
module stdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: design/stdm_ctrl.sv
`default_nettype none
module stdm_ctrl
  import stdm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == StIdle);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = StPrep;
        end
      end
      StPrep: begin
        if (sts.emit) begin
          cmd.start_run = 1'b1;
          state_nxt     = StEmit;
        end else begin
          state_nxt = StUpd;
        end
      end
      StEmit: begin
        cmd.in_run = 1'b1;
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.run_last) begin
            state_nxt = StUpd;
          end
        end
      end
      StUpd: begin
        cmd.update = 1'b1;
        state_nxt  = StIdle;
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/stdm_dpath.sv
`default_nettype none
module stdm_dpath
  import stdm_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int STAMP_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output      sts_t                sts,
  input  wire logic [WordW-1:0]    in_word,
  input  wire logic [StampW-1:0]   in_stamp,
  input  wire logic                cfg_valid,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDatW-1:0]  cfg_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [StampW-1:0]   out_stamp,
  output      logic [SlotW-1:0]    out_slot,
  output      logic [WordW-1:0]    out_value,
  output      logic                out_last
);

  localparam int AW   = $clog2(SLOTS);
  localparam int Keep = (STAMP_WIDTH < StampW) ? STAMP_WIDTH : StampW;
  localparam logic [SlotW:0]   SlotsW   = (SlotW+1)'(SLOTS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  logic                   subcom_r;
  logic [4:0]             sel_r;
  logic [4:0]             count_r;
  logic [WordW-1:0]       word_r;
  logic [StampW-1:0]      istamp_r;
  logic [STAMP_WIDTH-1:0] cstamp_r;
  logic                   changed_r, changed_nxt;
  logic [SLOTS-1:0]       vld_r;
  logic [SlotW-1:0]       slot_r, slot_nxt;
  logic [AW-1:0]          raddr, rq_r;
  logic [WordW-1:0]       rdata, stored;
  logic                   out_valid_r;

  logic [SlotW-1:0] idx, first_slot, last_slot, cnt_m1;
  logic [WordW-1:0] val;
  logic             starts, emit, idx_ok, sel_ok, do_write, slot_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subcom_r <= 1'b1;
      sel_r    <= SelAll;
      count_r  <= CountReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgSubcom: subcom_r <= cfg_data[0];
        CfgSelect: sel_r    <= cfg_data;
        CfgCount:  count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx    = subcom_r ? (word_r[SlotW-1:0] & IdxMask) : '0;
  assign val    = subcom_r ? {4'b0, word_r[WordW-1:4]} : word_r;
  assign starts = !subcom_r || (idx == '0);
  assign emit   = starts && changed_r && (cstamp_r != '0);
  assign idx_ok = {1'b0, idx} < SlotsW;
  assign sel_ok = (sel_r == SelAll) || (!sel_r[4] && (sel_r[3:0] == idx));

  always_comb begin
    if (count_r == '0) begin
      cnt_m1 = '0;
    end else if (count_r > SlotsW) begin
      cnt_m1 = LastSlot;
    end else begin
      cnt_m1 = SlotW'(count_r - 5'd1);
    end
    if (!subcom_r) begin
      first_slot = '0;
      last_slot  = '0;
    end else if (!sel_r[4]) begin
      first_slot = sel_r[3:0];
      last_slot  = sel_r[3:0];
    end else begin
      first_slot = '0;
      last_slot  = cnt_m1;
    end
  end

  assign stored   = vld_r[rq_r] ? rdata : '0;
  assign do_write = idx_ok && (stored != val) && sel_ok;
  assign slot_ok  = {1'b0, slot_r} < SlotsW;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.start_run) begin
      slot_nxt = first_slot;
    end else if (cmd.emit_load && (slot_r != last_slot)) begin
      slot_nxt = slot_r + SlotW'(1);
    end
    if (cmd.start_run || (cmd.in_run && !(cmd.emit_load && (slot_r == last_slot)))) begin
      raddr = slot_nxt[AW-1:0];
    end else begin
      raddr = idx[AW-1:0];
    end
  end

  always_comb begin
    changed_nxt = changed_r;
    if (!subcom_r || emit) begin
      changed_nxt = do_write;
    end else if (do_write) begin
      changed_nxt = 1'b1;
    end
  end

  stdm_ram #(
    .WIDTH (WordW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.update && do_write),
    .waddr (idx[AW-1:0]),
    .wdata (val),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      changed_r   <= 1'b1;
      cstamp_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        changed_r <= changed_nxt;
        if (do_write) begin
          vld_r[idx[AW-1:0]] <= 1'b1;
        end
        if (starts) begin
          cstamp_r <= STAMP_WIDTH'(istamp_r[Keep-1:0]);
        end
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rq_r   <= raddr;
    slot_r <= slot_nxt;
    if (cmd.capture) begin
      word_r   <= in_word;
      istamp_r <= in_stamp;
    end
    if (cmd.emit_load) begin
      out_stamp <= StampW'(cstamp_r[Keep-1:0]);
      out_slot  <= slot_r;
      out_value <= slot_ok ? stored : '0;
      out_last  <= (slot_r == last_slot);
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.emit     = emit;
  assign sts.run_last = (slot_r == last_slot);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire

FILE: design/subcom_telemetry_demux.sv
// channel  dir  handshake      payload
// in_ch    in   valid/ready    word[15:0], stamp[31:0]
// out_ch   out  valid/ready    out_stamp[31:0], slot[3:0], value[15:0], last
// cfg_ch   in   valid/ready=1  index[1:0], data[4:0]
//
// An item releases n results (0, 1 or up to SLOTS); the slot table RAM is
// read one slot a cycle through its single read port while out_ch is not
// stalled, then read and written once for the update.
// Reset (rst_n low, synchronous) clears the table valid bits and the cycle
// stamp, sets the change flag, and loads the register defaults.
// A stall on out_ch holds the run; in_ch is taken again only once the item
// has finished, while its last result may still be waiting.
`default_nettype none
module subcom_telemetry_demux
  import stdm_pkg::*;
#(
  parameter int SLOTS       = 16,
  parameter int STAMP_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  stdm_in_if.sink   in_ch,
  stdm_out_if.source out_ch,
  stdm_cfg_if.sink  cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  stdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stdm_dpath #(
    .SLOTS       (SLOTS),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_ch.word),
    .in_stamp  (in_ch.stamp),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_stamp (out_ch.out_stamp),
    .out_slot  (out_ch.slot),
    .out_value (out_ch.value),
    .out_last  (out_ch.last)
  );

endmodule
`default_nettype wire

FILE: design/stdm_chk.sv
`default_nettype none
module stdm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_stamp,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_stamp))
    else $error("stalled result stamp changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("item taken while previous one in progress");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind subcom_telemetry_demux stdm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_stamp (out_ch.out_stamp),
  .cfg_ready (cfg_ch.ready)
);
`default_nettype wire
